// ===== src/stack_queue_opcode_engine_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef STACK_QUEUE_OPCODE_ENGINE_TOP_ASSERT_SVH
`define STACK_QUEUE_OPCODE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SQOE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SQOE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sqoe_pkg.sv =====
package sqoe_pkg;

  localparam int VALUE_W  = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_PRINT = 3'd1,
    OP_PEEK  = 3'd2,
    OP_POP   = 3'd3,
    OP_SWAP  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_ARG    = 3'd1,
    ST_PEEK_EMPTY = 3'd2,
    ST_POP_EMPTY  = 3'd3,
    ST_SWAP_SHORT = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP2,
    S_PREAD,
    S_PEMIT
  } state_t;

endpackage

// ===== src/stack_queue_opcode_engine_top.sv =====
// Stack/queue opcode engine. Holds up to DEPTH signed 32-bit entries in a ring
// memory with one write port and two registered read ports. Each input
// transaction is one opcode: push (to the front when stack_mode is 1, to the
// back when 0), print all, peek, pop, or swap of the two front entries. Every
// opcode gives exactly one result transaction with last set, except print
// all, which gives one per entry (last on the final one, none if empty), and
// opcodes 5 to 7, which give none and change nothing. An error returns its
// status code and leaves the contents untouched. Push, peek, pop and unused
// opcodes are accepted and then executed on the read data; swap adds a
// second write state, since its two writes share the single write port; print
// all does one memory read and one emit per entry (just the accept and
// execute steps when the list is empty). Output stalls hold the engine.
// A finished result sits in the output register while the next transaction
// is accepted. stack_mode is written through cfg_we and cfg_wdata; the user
// must do so only while the engine is idle (not enforced here); it resets to 1.
module stack_queue_opcode_engine_top
  import sqoe_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           operation,
  input  logic signed [VALUE_W-1:0] push_value,
  input  logic                      argument_ok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic signed [VALUE_W-1:0] data_value,
  output logic                      data_valid,
  output logic                      last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  // Ring position: (base + offset) mod DEPTH, with base < DEPTH and
  // offset <= DEPTH, so one compare and subtract suffices.
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_t state, state_next;

  // Latched transaction
  logic [OP_W-1:0]    op_q;
  logic [VALUE_W-1:0] value_q;
  logic               ok_q;

  // Ring bookkeeping
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic          stack_mode;

  // Entry memory
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_a, rd_b;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [CW-1:0]      rd_off;
  logic [AW-1:0]      raddr_a, raddr_b;

  // Result staging
  logic               emit, out_free;
  status_t            e_status;
  logic [VALUE_W-1:0] e_data;
  logic               e_dvalid, e_last;

  logic [AW-1:0] front_dec, front_inc;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign front_dec = (front == '0) ? LAST_SLOT : front - AW'(1);
  assign front_inc = slot_add(front, CW'(1));
  assign raddr_a   = slot_add(front, rd_off);
  assign raddr_b   = front_inc;

  // Memory: one write, two registered reads; read data holds between reads
  // so the second swap write can reuse the first entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a <= mem[raddr_a];
      rd_b <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_data     = '0;
    e_dvalid   = 1'b0;
    e_last     = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = front;
    mem_wdata  = value_q;
    rd_off     = '0;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        // Fetch the two front entries alongside the accept.
        if (in_valid) begin
          mem_re     = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_PUSH: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (!ok_q) begin
                e_status = ST_BAD_ARG;
              end else if (count >= DEPTH_C) begin
                e_status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                if (stack_mode) begin
                  mem_waddr  = front_dec;
                  front_next = front_dec;
                end else begin
                  mem_waddr = slot_add(front, count);
                end
                count_next = count + CW'(1);
              end
            end
          end
          OP_PEEK: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (count == '0) begin
                e_status = ST_PEEK_EMPTY;
              end else begin
                e_data   = rd_a;
                e_dvalid = 1'b1;
              end
            end
          end
          OP_POP: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (count == '0) begin
                e_status = ST_POP_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - CW'(1);
              end
            end
          end
          OP_SWAP: begin
            if (out_free) begin
              emit = 1'b1;
              if (count < CW'(2)) begin
                e_status   = ST_SWAP_SHORT;
                state_next = S_IDLE;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = front;
                mem_wdata  = rd_b;
                state_next = S_SWAP2;
              end
            end
          end
          OP_PRINT: begin
            if (count == '0) begin
              state_next = S_IDLE;
            end else if (out_free) begin
              emit     = 1'b1;
              e_data   = rd_a;
              e_dvalid = 1'b1;
              e_last   = (count == CW'(1));
              if (count == CW'(1)) begin
                state_next = S_IDLE;
              end else begin
                idx_next   = CW'(1);
                state_next = S_PREAD;
              end
            end
          end
          default: begin
            // Unused opcode: drop it.
            state_next = S_IDLE;
          end
        endcase
      end
      S_SWAP2: begin
        mem_we     = 1'b1;
        mem_waddr  = front_inc;
        mem_wdata  = rd_a;
        state_next = S_IDLE;
      end
      S_PREAD: begin
        mem_re     = 1'b1;
        rd_off     = idx;
        state_next = S_PEMIT;
      end
      S_PEMIT: begin
        if (out_free) begin
          emit     = 1'b1;
          e_data   = rd_a;
          e_dvalid = 1'b1;
          e_last   = (idx + CW'(1) == count);
          if (idx + CW'(1) == count) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_PREAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture the transaction on accept.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= operation;
      value_q <= push_value;
      ok_q    <= argument_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      count      <= '0;
      idx        <= '0;
      stack_mode <= 1'b1;
    end else begin
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
      if (cfg_we) begin
        stack_mode <= cfg_wdata;
      end
    end
  end

  // Output register: load on emit, clear when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status     <= e_status;
      data_value <= e_data;
      data_valid <= e_dvalid;
      last       <= e_last;
    end
  end

endmodule

// ===== src/sqoe_checker.sv =====
`include "stack_queue_opcode_engine_top_assert.svh"

module sqoe_checker
  import sqoe_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [STATUS_W-1:0]       status,
  input logic signed [VALUE_W-1:0] data_value,
  input logic                      data_valid,
  input logic                      last
);

  // A stalled result holds its payload.
  `SQOE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(data_value) && $stable(status), "stalled result changed")

  // Only successful peek or print results carry an entry.
  `SQOE_ASSERT_IMP(a_data_ok, clk, rst, out_valid && data_valid, status == ST_OK, "entry reported with error status")

  // An error ends its transaction and carries no entry.
  `SQOE_ASSERT_IMP(a_err_last, clk, rst, out_valid && (status != ST_OK), last && !data_valid, "error result not final or carries data")

  // Nothing is presented right after reset.
  `SQOE_ASSERT_IMP(a_rst_quiet, clk, rst, $past(rst), !out_valid, "result presented after reset")

endmodule

bind stack_queue_opcode_engine_top sqoe_checker u_sqoe_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .data_value (data_value),
  .data_valid (data_valid),
  .last       (last)
);
